// ===== design/int_to_base_charset_digits_macros.svh =====
// Assertion shorthands used by the checker file.
`ifndef INT_TO_BASE_CHARSET_DIGITS_MACROS_SVH
`define INT_TO_BASE_CHARSET_DIGITS_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define IBCD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define IBCD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/ibcd_pkg.sv =====
package ibcd_pkg;

   localparam int TABLE_SIZE = 16;
   localparam int CHAR_W     = 8;
   localparam int DIGIT_W    = 4;
   localparam int BASE_LEN_W = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;
   localparam int TABLE_W    = TABLE_SIZE * CHAR_W;

   localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
   localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_LEN     = 2'd0,
      CSR_CHARSET_LOW  = 2'd1,
      CSR_CHARSET_HIGH = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic                done;
      logic                quot_zero;
      logic [DIGIT_W-1:0]  digit;
   } div_stat_type;

endpackage

// ===== design/ibcd_ifs.sv =====
interface ibcd_req_if #(parameter int VALUE_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface ibcd_rsp_if;
   import ibcd_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] out_char;
   logic              last;
   logic              bad_charset;

   modport source (output valid, output out_char, output last, output bad_charset,
                   input ready);
   modport sink (input valid, input out_char, input last, input bad_charset,
                 output ready);
endinterface

interface ibcd_csr_if;
   import ibcd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/ibcd_div.sv =====
module ibcd_div #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [VALUE_WIDTH-1:0]           dividend,
   input  logic [ibcd_pkg::BASE_LEN_W-1:0]  radix,
   output logic [VALUE_WIDTH-1:0]           quotient,
   output ibcd_pkg::div_stat_type           stat
);
   import ibcd_pkg::*;

   localparam int BITS_PER_CYC = 4;
   localparam int STEPS        = (VALUE_WIDTH + BITS_PER_CYC - 1) / BITS_PER_CYC;
   localparam int PAD_W        = STEPS * BITS_PER_CYC;
   localparam int CNT_W        = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic [PAD_W-1:0]   dv_ff;
   logic [DIGIT_W-1:0] rem_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff;
   logic               done_ff;

   logic [PAD_W-1:0]   dv_in;
   logic [DIGIT_W-1:0] rem_in;

   // Restoring division, a few bits per cycle; remainder stays below radix.
   always_comb begin
      logic [DIGIT_W:0]   trial;
      logic [PAD_W-1:0]   dv_v;
      logic [DIGIT_W-1:0] rem_v;
      dv_v  = dv_ff;
      rem_v = rem_ff;
      for (int k = 0; k < BITS_PER_CYC; k++) begin
         trial = {rem_v, dv_v[PAD_W-1]};
         if (trial >= radix) begin
            rem_v = DIGIT_W'(trial - radix);
            dv_v  = {dv_v[PAD_W-2:0], 1'b1};
         end else begin
            rem_v = trial[DIGIT_W-1:0];
            dv_v  = {dv_v[PAD_W-2:0], 1'b0};
         end
      end
      dv_in  = dv_v;
      rem_in = rem_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         dv_ff   <= PAD_W'(dividend);
         rem_ff  <= '0;
         cnt_ff  <= '0;
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff) begin
         dv_ff  <= dv_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign quotient       = dv_ff[VALUE_WIDTH-1:0];
   assign stat.done      = done_ff;
   assign stat.quot_zero = (dv_ff == '0);
   assign stat.digit     = rem_ff;

endmodule

// ===== design/int_to_base_charset_digits.sv =====
// Each digit takes one pass of the radix divider; after reset or a register write the
// table is checked entry by entry on the next item, before its first digit.
// A new item is taken only in idle, once the last beat of the previous one is loaded;
// beats go out one per cycle while the receiver is ready.
// Reset (synchronous): flags, base length and table clear; table unchecked; no beat held.
module int_to_base_charset_digits #(
   parameter int MAX_BASE    = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   ibcd_req_if.sink    req_ch,
   ibcd_rsp_if.source  rsp_ch,
   ibcd_csr_if.sink    csr_ch
);
   import ibcd_pkg::*;

   localparam int ND_W     = $clog2(VALUE_WIDTH + 1);
   localparam int STK_W    = VALUE_WIDTH * DIGIT_W;
   localparam int BASE_CAP = (MAX_BASE < TABLE_SIZE) ? MAX_BASE : TABLE_SIZE;
   localparam int IDX_W    = $clog2(TABLE_SIZE);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_SIGN,
      ST_EMIT,
      ST_BAD
   } state_type;

   state_type             state_ff;
   logic [BASE_LEN_W-1:0] base_len_ff;
   logic [TABLE_W-1:0]    charset_ff;
   logic                  chk_done_ff;
   logic                  chk_bad_ff;
   logic [IDX_W-1:0]      chk_idx_ff;
   logic                  neg_ff;
   logic [VALUE_WIDTH-1:0] mag_ff;
   logic [STK_W-1:0]      stk_ff;
   logic [ND_W-1:0]       nd_ff;
   logic                  div_start_ff;
   logic                  rsp_valid_ff;
   logic [CHAR_W-1:0]     out_char_ff;
   logic                  last_ff;
   logic                  bad_ff;

   logic [VALUE_WIDTH-1:0] quotient;
   div_stat_type           div_stat;
   logic                   out_free;
   logic                   range_bad;
   logic                   entry_bad;
   logic [CHAR_W-1:0]      chk_char;
   logic [CHAR_W-1:0]      pop_char;
   logic                   req_neg;
   logic [VALUE_WIDTH-1:0] req_mag;
   logic                   chk_last;
   logic                   beat_load;
   logic                   div_start_in;

   function automatic logic [CHAR_W-1:0] table_char(input logic [TABLE_W-1:0] tbl,
                                                    input logic [IDX_W-1:0]   idx);
      return tbl[{idx, 3'b000} +: CHAR_W];
   endfunction

   ibcd_div #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (mag_ff),
      .radix    (base_len_ff),
      .quotient (quotient),
      .stat     (div_stat)
   );

   assign range_bad = (base_len_ff < BASE_LEN_W'(2)) ||
                      (base_len_ff > BASE_LEN_W'(BASE_CAP));
   assign chk_char  = table_char(charset_ff, chk_idx_ff);
   assign pop_char  = table_char(charset_ff, stk_ff[DIGIT_W-1:0]);
   assign req_neg   = req_ch.value[VALUE_WIDTH-1];
   assign req_mag   = req_neg ? (~req_ch.value + 1'b1) : req_ch.value;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign chk_last  = (chk_idx_ff == IDX_W'(TABLE_SIZE - 1));
   assign beat_load = out_free &&
                      (state_ff == ST_SIGN || state_ff == ST_EMIT || state_ff == ST_BAD);

   // Kick the divider on a fresh item, after a clean table check, or for the next digit.
   assign div_start_in =
      ((state_ff == ST_IDLE) && req_ch.valid && chk_done_ff && !chk_bad_ff) ||
      ((state_ff == ST_CHECK) && chk_last && !(chk_bad_ff || entry_bad || range_bad)) ||
      ((state_ff == ST_DIV) && div_stat.done && !div_stat.quot_zero);

   // One table entry per cycle: against sign chars and every later entry in use.
   always_comb begin
      logic dup;
      dup = 1'b0;
      for (int j = 0; j < TABLE_SIZE; j++) begin
         if ((IDX_W'(j) > chk_idx_ff) && (BASE_LEN_W'(j) < base_len_ff) &&
             (table_char(charset_ff, IDX_W'(j)) == chk_char))
            dup = 1'b1;
      end
      entry_bad = ({1'b0, chk_idx_ff} < base_len_ff) &&
                  (dup || chk_char == PLUS_CHAR || chk_char == MINUS_CHAR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_len_ff  <= '0;
         charset_ff   <= '0;
         chk_done_ff  <= 1'b0;
         chk_bad_ff   <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_start_ff <= div_start_in;
         if (beat_load)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready)
            rsp_valid_ff <= 1'b0;

         if (csr_ch.valid) begin
            chk_done_ff <= 1'b0;
            unique case (csr_ch.index)
               CSR_BASE_LEN:     base_len_ff <= csr_ch.data[BASE_LEN_W-1:0];
               CSR_CHARSET_LOW:  charset_ff[CSR_DATA_W-1:0] <= csr_ch.data;
               CSR_CHARSET_HIGH: charset_ff[TABLE_W-1:CSR_DATA_W] <= csr_ch.data;
               default: ;
            endcase
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  neg_ff <= req_neg;
                  mag_ff <= req_mag;
                  nd_ff  <= '0;
                  if (!chk_done_ff) begin
                     chk_idx_ff <= '0;
                     chk_bad_ff <= 1'b0;
                     state_ff   <= ST_CHECK;
                  end else if (chk_bad_ff) begin
                     state_ff <= ST_BAD;
                  end else begin
                     state_ff <= ST_DIV;
                  end
               end
            end
            ST_CHECK: begin
               chk_idx_ff <= chk_idx_ff + 1'b1;
               if (chk_last) begin
                  chk_done_ff <= 1'b1;
                  chk_bad_ff  <= chk_bad_ff || entry_bad || range_bad;
                  if (chk_bad_ff || entry_bad || range_bad)
                     state_ff <= ST_BAD;
                  else
                     state_ff <= ST_DIV;
               end else if (entry_bad) begin
                  chk_bad_ff <= 1'b1;
               end
            end
            ST_DIV: begin
               if (div_stat.done) begin
                  // Push: the last digit found is the most significant.
                  stk_ff <= {stk_ff[STK_W-DIGIT_W-1:0], div_stat.digit};
                  nd_ff  <= nd_ff + 1'b1;
                  mag_ff <= quotient;
                  if (div_stat.quot_zero)
                     state_ff <= neg_ff ? ST_SIGN : ST_EMIT;
               end
            end
            ST_SIGN: begin
               if (out_free) begin
                  out_char_ff  <= MINUS_CHAR;
                  last_ff      <= 1'b0;
                  bad_ff       <= 1'b0;
                  state_ff     <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  out_char_ff  <= pop_char;
                  last_ff      <= (nd_ff == ND_W'(1));
                  bad_ff       <= 1'b0;
                  stk_ff       <= stk_ff >> DIGIT_W;
                  nd_ff        <= nd_ff - 1'b1;
                  if (nd_ff == ND_W'(1))
                     state_ff <= ST_IDLE;
               end
            end
            ST_BAD: begin
               if (out_free) begin
                  out_char_ff  <= '0;
                  last_ff      <= 1'b1;
                  bad_ff       <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign csr_ch.ready       = 1'b1;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_char    = out_char_ff;
   assign rsp_ch.last        = last_ff;
   assign rsp_ch.bad_charset = bad_ff;

endmodule

// ===== design/ibcd_checker.sv =====
`include "int_to_base_charset_digits_macros.svh"

module ibcd_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [ibcd_pkg::CHAR_W-1:0] out_char,
   input logic                      last,
   input logic                      bad_charset
);
   import ibcd_pkg::*;

   `IBCD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable({out_char, last, bad_charset}), "stalled result beat changed")
   `IBCD_ASSERT_SAME(a_bad_alone, rsp_valid && bad_charset, last && out_char == '0, "error beat must be a lone empty last beat")
   `IBCD_ASSERT_SAME(a_sign_not_last, rsp_valid && !bad_charset && out_char == MINUS_CHAR, !last, "minus sign must be followed by digits")
   `IBCD_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "input taken again before conversion ran")

endmodule

bind int_to_base_charset_digits ibcd_checker u_ibcd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .out_char    (rsp_ch.out_char),
   .last        (rsp_ch.last),
   .bad_charset (rsp_ch.bad_charset)
);
